### src/e2q_pkg.sv
`default_nettype none

package e2q_pkg;

    localparam int ANGLE_W = 24;
    // CORDIC datapath width; components stay near 2^30 in magnitude.
    localparam int CW = 34;
    // Width of a clamped sine or cosine, range [-2^30, 2^30].
    localparam int SCW = 32;
    localparam int PW = 64;

    // 46 half periods of 184320 units, so every 24-bit angle becomes positive.
    localparam logic [ANGLE_W:0] ANGLE_OFFSET = 25'd8478720;

    // The half period is 180 * 1024 units and a quadrant is 45 * 1024 units.
    localparam int TW = 15;
    localparam logic [TW-1:0] T_RECIP = 15'd23302;
    localparam int T_SHIFT = 22;
    localparam logic [TW-1:0] T_PERIOD = 15'd180;
    localparam logic [7:0] QUAD_SPAN1 = 8'd45;
    localparam logic [7:0] QUAD_SPAN2 = 8'd90;
    localparam logic [7:0] QUAD_SPAN3 = 8'd135;

    // z = floor(m * 2^20 / 45) as floor(m * ceil(2^42 / 45) / 2^22).
    localparam int MW = 16;
    localparam int ZRW = 37;
    localparam logic [ZRW-1:0] Z_RECIP = 37'd97734366914;
    localparam int Z_SHIFT = 22;
    localparam int ZW = 30;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;

    localparam int ATAN_LEN = 24;
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    localparam logic signed [PW-1:0] PAIR_RND = 64'sd536870912;
    localparam int PAIR_SHIFT = 30;
    // Scale of the sum of two triple products (Q60).
    localparam int SUM_FRAC = 60;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    function automatic logic signed [SCW-1:0] sat_q30(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        begin
            if (v > ONE_Q30)
            begin
                r = ONE_Q30;
            end
            else if (v < -ONE_Q30)
            begin
                r = -ONE_Q30;
            end
            else
            begin
                r = v;
            end
            return r[SCW-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### src/e2q_sincos.sv
`default_nettype none

// Sine and cosine of half an angle, one CORDIC step per stage.
module e2q_sincos #(
    parameter int ROTATION_STEPS = 16
) (
    input  wire                                          clk,
    input  wire  [ROTATION_STEPS+3:0]                    adv,
    input  wire  logic signed [e2q_pkg::ANGLE_W-1:0]     angle,
    output logic signed [e2q_pkg::SCW-1:0]               sin_half,
    output logic signed [e2q_pkg::SCW-1:0]               cos_half
);

    localparam int CW = e2q_pkg::CW;
    localparam int TW = e2q_pkg::TW;
    localparam int FIN = ROTATION_STEPS + 3;

    // Stage 0: offset to a positive value and estimate the half-period count.
    logic [e2q_pkg::ANGLE_W:0] u_next;
    logic [2*TW-1:0]           tprod_next;
    logic [TW-1:0]             t0_reg;
    logic [9:0]                lo0_reg;
    logic [6:0]                qt0_reg;

    assign u_next     = {angle[e2q_pkg::ANGLE_W-1], angle} + e2q_pkg::ANGLE_OFFSET;
    assign tprod_next = (2*TW)'(u_next[e2q_pkg::ANGLE_W:10]) * (2*TW)'(e2q_pkg::T_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            t0_reg  <= u_next[e2q_pkg::ANGLE_W:10];
            lo0_reg <= u_next[9:0];
            qt0_reg <= tprod_next[e2q_pkg::T_SHIFT+6:e2q_pkg::T_SHIFT];
        end
    end

    // Stage 1: remainder within the half period, then quadrant and offset in it.
    logic [TW-1:0]       tm_full;
    logic [7:0]          tm;
    logic [7:0]          mhi_full;
    e2q_pkg::quad_t      q_next;
    e2q_pkg::quad_t      q1_reg;
    logic [e2q_pkg::MW-1:0] m1_reg;

    assign tm_full = t0_reg - TW'(qt0_reg) * e2q_pkg::T_PERIOD;
    assign tm      = tm_full[7:0];

    always_comb
    begin
        priority if (tm >= e2q_pkg::QUAD_SPAN3)
        begin
            q_next   = e2q_pkg::QUAD_3;
            mhi_full = tm - e2q_pkg::QUAD_SPAN3;
        end
        else if (tm >= e2q_pkg::QUAD_SPAN2)
        begin
            q_next   = e2q_pkg::QUAD_2;
            mhi_full = tm - e2q_pkg::QUAD_SPAN2;
        end
        else if (tm >= e2q_pkg::QUAD_SPAN1)
        begin
            q_next   = e2q_pkg::QUAD_1;
            mhi_full = tm - e2q_pkg::QUAD_SPAN1;
        end
        else
        begin
            q_next   = e2q_pkg::QUAD_0;
            mhi_full = tm;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            q1_reg <= q_next;
            m1_reg <= {mhi_full[5:0], lo0_reg};
        end
    end

    // Stage 2: scale the remainder so that 90 degrees is 2^30.
    localparam int ZPW = e2q_pkg::MW + e2q_pkg::ZRW;
    logic [ZPW-1:0]        zprod_next;
    logic signed [CW-1:0]  z2_reg;
    e2q_pkg::quad_t        q2_reg;

    assign zprod_next = ZPW'(m1_reg) * ZPW'(e2q_pkg::Z_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            z2_reg <= $signed(CW'(zprod_next[e2q_pkg::Z_SHIFT+e2q_pkg::ZW-1:e2q_pkg::Z_SHIFT]));
            q2_reg <= q1_reg;
        end
    end

    // CORDIC rotation, one step per stage.
    logic signed [CW-1:0] cx_reg [ROTATION_STEPS];
    logic signed [CW-1:0] cy_reg [ROTATION_STEPS];
    logic signed [CW-1:0] cz_reg [ROTATION_STEPS];
    e2q_pkg::quad_t       cq_reg [ROTATION_STEPS];

    for (genvar i = 0; i < ROTATION_STEPS; i++)
    begin : g_step
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [CW-1:0] z_in;
        logic signed [CW-1:0] ang;
        e2q_pkg::quad_t       q_in;

        if (i == 0)
        begin : g_first
            assign x_in = e2q_pkg::CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = z2_reg;
            assign q_in = q2_reg;
        end
        else
        begin : g_next
            assign x_in = cx_reg[i-1];
            assign y_in = cy_reg[i-1];
            assign z_in = cz_reg[i-1];
            assign q_in = cq_reg[i-1];
        end

        assign ang = $signed({{(CW-32){1'b0}}, e2q_pkg::ATAN_TAB[i]});

        always_ff @(posedge clk)
        begin
            if (adv[3+i])
            begin
                if (!z_in[CW-1])
                begin
                    cx_reg[i] <= x_in - (y_in >>> i);
                    cy_reg[i] <= y_in + (x_in >>> i);
                    cz_reg[i] <= z_in - ang;
                end
                else
                begin
                    cx_reg[i] <= x_in + (y_in >>> i);
                    cy_reg[i] <= y_in - (x_in >>> i);
                    cz_reg[i] <= z_in + ang;
                end
                cq_reg[i] <= q_in;
            end
        end
    end

    // Final stage: fold the quadrant back in by swaps and negations, then clamp.
    logic signed [CW-1:0] s_next;
    logic signed [CW-1:0] c_next;
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fy;

    assign fx = cx_reg[ROTATION_STEPS-1];
    assign fy = cy_reg[ROTATION_STEPS-1];

    always_comb
    begin
        unique case (cq_reg[ROTATION_STEPS-1])
            e2q_pkg::QUAD_0:
            begin
                s_next = fy;
                c_next = fx;
            end
            e2q_pkg::QUAD_1:
            begin
                s_next = fx;
                c_next = -fy;
            end
            e2q_pkg::QUAD_2:
            begin
                s_next = -fy;
                c_next = -fx;
            end
            default:
            begin
                s_next = -fx;
                c_next = fy;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[FIN])
        begin
            sin_half <= e2q_pkg::sat_q30(s_next);
            cos_half <= e2q_pkg::sat_q30(c_next);
        end
    end

endmodule

`default_nettype wire

### src/euler_to_quaternion.sv
`default_nettype none

// The pipeline holds angle reduction, then one CORDIC step per stage, then the
// product tree.
// Throughput: one item per cycle while the output is not stalled; a stalled output holds its item and bubbles in
// the pipeline still fill behind it.
// Reset clears the valid bit of every stage; data registers are not reset.
module euler_to_quaternion #(
    parameter int ROTATION_STEPS = 16,
    parameter int OUT_WIDTH      = 16
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire                                      in_valid,
    output logic                                     in_ready,
    input  wire  logic signed [e2q_pkg::ANGLE_W-1:0] pitch_angle,
    input  wire  logic signed [e2q_pkg::ANGLE_W-1:0] yaw_angle,
    input  wire  logic signed [e2q_pkg::ANGLE_W-1:0] roll_angle,
    output logic                                     out_valid,
    input  wire                                      out_ready,
    output logic signed [OUT_WIDTH-1:0]              quat_x,
    output logic signed [OUT_WIDTH-1:0]              quat_y,
    output logic signed [OUT_WIDTH-1:0]              quat_z,
    output logic signed [OUT_WIDTH-1:0]              quat_w
);

    localparam int PW   = e2q_pkg::PW;
    localparam int SCW  = e2q_pkg::SCW;
    localparam int NSC  = ROTATION_STEPS + 4;
    localparam int NS   = NSC + 5;
    localparam int F    = OUT_WIDTH - 1;
    localparam int SH   = e2q_pkg::SUM_FRAC - F;
    localparam logic signed [PW-1:0] OUT_RND = 64'sd1 <<< (SH - 1);
    localparam logic signed [PW-1:0] OUT_MAX = (64'sd1 <<< F) - 64'sd1;
    localparam logic signed [PW-1:0] OUT_MIN = -(64'sd1 <<< F);

    // Stage control: a stage loads when it is empty or its item moves on.
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS:0]   rdy;
    logic [NS-1:0] adv;

    assign rdy[NS] = out_ready;
    for (genvar k = 0; k < NS; k++)
    begin : g_rdy
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
    end
    assign adv = rdy[NS-1:0];

    always_comb
    begin
        valid_next = {valid_reg[NS-2:0], in_valid};
        for (int k = 0; k < NS; k++)
        begin
            if (!adv[k])
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NS-1];

    // Half-angle sine and cosine of the three angles.
    logic signed [SCW-1:0] sp;
    logic signed [SCW-1:0] cp;
    logic signed [SCW-1:0] sy;
    logic signed [SCW-1:0] cy;
    logic signed [SCW-1:0] sr;
    logic signed [SCW-1:0] cr;

    e2q_sincos #(.ROTATION_STEPS(ROTATION_STEPS)) u_pitch (
        .clk      (clk),
        .adv      (adv[NSC-1:0]),
        .angle    (pitch_angle),
        .sin_half (sp),
        .cos_half (cp)
    );

    e2q_sincos #(.ROTATION_STEPS(ROTATION_STEPS)) u_yaw (
        .clk      (clk),
        .adv      (adv[NSC-1:0]),
        .angle    (yaw_angle),
        .sin_half (sy),
        .cos_half (cy)
    );

    e2q_sincos #(.ROTATION_STEPS(ROTATION_STEPS)) u_roll (
        .clk      (clk),
        .adv      (adv[NSC-1:0]),
        .angle    (roll_angle),
        .sin_half (sr),
        .cos_half (cr)
    );

    // Roll times pitch products: cr*sp, sr*cp, cr*cp, sr*sp.
    logic signed [PW-1:0]  pair_reg [4];
    logic signed [SCW-1:0] sy0_reg;
    logic signed [SCW-1:0] cy0_reg;

    always_ff @(posedge clk)
    begin
        if (adv[NSC])
        begin
            pair_reg[0] <= PW'(cr) * PW'(sp);
            pair_reg[1] <= PW'(sr) * PW'(cp);
            pair_reg[2] <= PW'(cr) * PW'(cp);
            pair_reg[3] <= PW'(sr) * PW'(sp);
            sy0_reg     <= sy;
            cy0_reg     <= cy;
        end
    end

    // Round the pair products back to Q30.
    logic signed [SCW-1:0] rpair_reg [4];
    logic signed [PW-1:0]  rsum_next [4];
    logic signed [SCW-1:0] sy1_reg;
    logic signed [SCW-1:0] cy1_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rsum_next[k] = (pair_reg[k] + e2q_pkg::PAIR_RND) >>> e2q_pkg::PAIR_SHIFT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NSC+1])
        begin
            for (int k = 0; k < 4; k++)
            begin
                rpair_reg[k] <= rsum_next[k][SCW-1:0];
            end
            sy1_reg <= sy0_reg;
            cy1_reg <= cy0_reg;
        end
    end

    // Times the yaw factor, Q60.
    logic signed [PW-1:0] tri_reg [8];

    always_ff @(posedge clk)
    begin
        if (adv[NSC+2])
        begin
            tri_reg[0] <= PW'(rpair_reg[0]) * PW'(sy1_reg);
            tri_reg[1] <= PW'(rpair_reg[1]) * PW'(cy1_reg);
            tri_reg[2] <= PW'(rpair_reg[0]) * PW'(cy1_reg);
            tri_reg[3] <= PW'(rpair_reg[1]) * PW'(sy1_reg);
            tri_reg[4] <= PW'(rpair_reg[2]) * PW'(sy1_reg);
            tri_reg[5] <= PW'(rpair_reg[3]) * PW'(cy1_reg);
            tri_reg[6] <= PW'(rpair_reg[2]) * PW'(cy1_reg);
            tri_reg[7] <= PW'(rpair_reg[3]) * PW'(sy1_reg);
        end
    end

    // Combine into x, y, z, w under the pitch-yaw-roll sign convention.
    logic signed [PW-1:0] sum_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv[NSC+3])
        begin
            sum_reg[0] <= tri_reg[0] - tri_reg[1];
            sum_reg[1] <= -tri_reg[2] - tri_reg[3];
            sum_reg[2] <= tri_reg[4] - tri_reg[5];
            sum_reg[3] <= tri_reg[6] + tri_reg[7];
        end
    end

    // Round to the output format and saturate; +1.0 lands on the largest code.
    logic signed [PW-1:0]        ovr_next [4];
    logic signed [OUT_WIDTH-1:0] out_next [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ovr_next[k] = (sum_reg[k] + OUT_RND) >>> SH;
            if (ovr_next[k] > OUT_MAX)
            begin
                out_next[k] = OUT_MAX[OUT_WIDTH-1:0];
            end
            else if (ovr_next[k] < OUT_MIN)
            begin
                out_next[k] = OUT_MIN[OUT_WIDTH-1:0];
            end
            else
            begin
                out_next[k] = ovr_next[k][OUT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NSC+4])
        begin
            quat_x <= out_next[0];
            quat_y <= out_next[1];
            quat_z <= out_next[2];
            quat_w <= out_next[3];
        end
    end

endmodule

`default_nettype wire
